// ----- hdl/spt_pkg.sv -----
// Shared constants, register indexes and the result word type for the
// four-channel servo PWM timer. No dependencies.
`default_nettype none

package spt_pkg;

    localparam int MAX_CHANNELS    = 4;
    localparam int CHANNELS_DEF    = 4;
    localparam int COUNT_WIDTH_DEF = 16;
    localparam int FIELD_W         = 16;
    localparam int CFG_INDEX_W     = 2;

    localparam logic [FIELD_W-1:0] PULSE_LIMIT  = 16'd1000;
    localparam logic [FIELD_W-1:0] COMPARE_BASE = 16'd19000;
    localparam logic [31:0]        PERIOD_RST   = 32'h0000_FFFF;

    localparam logic [CFG_INDEX_W-1:0] REG_PERIOD_RELOAD   = 2'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_PRESCALE_DIVIDE = 2'd1;

    localparam logic CMD_TICK = 1'b0;
    localparam logic CMD_LOAD = 1'b1;

    typedef struct packed {
        logic [MAX_CHANNELS-1:0] level;
        logic [FIELD_W-1:0]      count;
        logic                    update;
    } result_t;

endpackage

`default_nettype wire

// ----- hdl/spt_if.sv -----
// Handshake channels of the servo PWM timer: input word, result word and
// configuration write. Depends on spt_pkg.
`default_nettype none

interface spt_item_if;
    logic        valid;
    logic        ready;
    logic        cmd;
    logic [15:0] pulse_ch1;
    logic [15:0] pulse_ch2;
    logic [15:0] pulse_ch3;
    logic [15:0] pulse_ch4;

    modport source (output valid, cmd, pulse_ch1, pulse_ch2, pulse_ch3, pulse_ch4,
                    input ready);
    modport sink   (input valid, cmd, pulse_ch1, pulse_ch2, pulse_ch3, pulse_ch4,
                    output ready);
endinterface

interface spt_result_if;
    logic        valid;
    logic        ready;
    logic        level_ch1;
    logic        level_ch2;
    logic        level_ch3;
    logic        level_ch4;
    logic [15:0] count_value;
    logic        update_event;

    modport source (output valid, level_ch1, level_ch2, level_ch3, level_ch4,
                    count_value, update_event, input ready);
    modport sink   (input valid, level_ch1, level_ch2, level_ch3, level_ch4,
                    count_value, update_event, output ready);
endinterface

interface spt_cfg_if;
    logic                           valid;
    logic                           ready;
    logic [spt_pkg::CFG_INDEX_W-1:0] index;
    logic [15:0]                    data;

    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

`default_nettype wire

// ----- hdl/spt_core.sv -----
// Timer state: config registers, prescaler, main counter, compare preload
// and active compares; builds the result word. Depends on spt_pkg.
`default_nettype none

module spt_core #(
    parameter int CHANNELS    = spt_pkg::CHANNELS_DEF,
    parameter int COUNT_WIDTH = spt_pkg::COUNT_WIDTH_DEF
) (
    input  wire logic                                   clk,
    input  wire logic                                   rst_n,
    input  wire logic                                   acc,
    input  wire logic                                   cmd,
    input  wire logic [spt_pkg::MAX_CHANNELS-1:0][15:0] pulse,
    input  wire logic                                   cfg_we,
    input  wire logic [spt_pkg::CFG_INDEX_W-1:0]        cfg_index,
    input  wire logic [15:0]                            cfg_data,
    output spt_pkg::result_t                            res
);

    logic [COUNT_WIDTH-1:0] period_reg;
    logic [15:0]            prescale_div_reg;
    logic [15:0]            prescale_reg;
    logic [15:0]            prescale_next;
    logic [COUNT_WIDTH-1:0] main_count_reg;
    logic [COUNT_WIDTH-1:0] main_count_next;
    logic [spt_pkg::MAX_CHANNELS-1:0][15:0] active_reg;
    logic [spt_pkg::MAX_CHANNELS-1:0][15:0] active_next;
    logic [spt_pkg::MAX_CHANNELS-1:0][15:0] preload_reg;
    logic [spt_pkg::MAX_CHANNELS-1:0][15:0] preload_next;
    logic                   wrapped;
    logic [31:0]            cfg_ext;
    logic [31:0]            count_ext;
    logic [15:0]            clamped;

    assign cfg_ext = 32'(cfg_data);

    always_comb
    begin
        prescale_next   = prescale_reg;
        main_count_next = main_count_reg;
        active_next     = active_reg;
        preload_next    = preload_reg;
        wrapped         = 1'b0;
        clamped         = '0;
        if (cmd == spt_pkg::CMD_LOAD)
        begin
            for (int i = 0; i < spt_pkg::MAX_CHANNELS; i++)
            begin
                clamped = (pulse[i] > spt_pkg::PULSE_LIMIT) ? spt_pkg::PULSE_LIMIT
                                                            : pulse[i];
                if (i < CHANNELS)
                begin
                    preload_next[i] = spt_pkg::COMPARE_BASE - clamped;
                end
            end
        end
        else if (prescale_reg >= prescale_div_reg)
        begin
            prescale_next = '0;
            if (main_count_reg >= period_reg)
            begin
                main_count_next = '0;
                wrapped         = 1'b1;
                active_next     = preload_reg;
            end
            else
            begin
                main_count_next = main_count_reg + COUNT_WIDTH'(1);
            end
        end
        else
        begin
            prescale_next = prescale_reg + 16'd1;
        end
    end

    assign count_ext = 32'(main_count_next);

    always_comb
    begin
        res.count  = count_ext[15:0];
        res.update = wrapped;
        for (int i = 0; i < spt_pkg::MAX_CHANNELS; i++)
        begin
            res.level[i] = (i < CHANNELS) && (count_ext >= 32'(active_next[i]));
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            period_reg       <= spt_pkg::PERIOD_RST[COUNT_WIDTH-1:0];
            prescale_div_reg <= '0;
            prescale_reg     <= '0;
            main_count_reg   <= '0;
            active_reg       <= '0;
            preload_reg      <= '0;
        end
        else
        begin
            if (cfg_we && cfg_index == spt_pkg::REG_PERIOD_RELOAD)
            begin
                period_reg <= cfg_ext[COUNT_WIDTH-1:0];
            end
            if (cfg_we && cfg_index == spt_pkg::REG_PRESCALE_DIVIDE)
            begin
                prescale_div_reg <= cfg_data;
            end
            if (acc)
            begin
                prescale_reg   <= prescale_next;
                main_count_reg <= main_count_next;
                active_reg     <= active_next;
                preload_reg    <= preload_next;
            end
        end
    end

`ifndef SYNTHESIS
    a_load_holds_count: assert property (@(posedge clk) disable iff (!rst_n)
        acc && cmd == spt_pkg::CMD_LOAD |=> $stable(main_count_reg) && $stable(prescale_reg))
        else $error("load word moved the counter");
    a_wrap_to_zero: assert property (@(posedge clk) disable iff (!rst_n)
        acc && res.update |=> main_count_reg == '0 && prescale_reg == '0)
        else $error("update without counter wrap");
    a_update_only_on_tick: assert property (@(posedge clk) disable iff (!rst_n)
        res.update |-> cmd == spt_pkg::CMD_TICK)
        else $error("update flag on a load word");
`endif

endmodule

`default_nettype wire

// ----- hdl/spt_out_buf.sv -----
// Output register with a skid stage so the input side is decoupled from
// result back-pressure. Depends on spt_pkg.
`default_nettype none

module spt_out_buf (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             in_valid,
    output logic                  in_ready,
    input  wire spt_pkg::result_t in_data,
    output logic                  out_valid,
    input  wire logic             out_ready,
    output spt_pkg::result_t      out_data
);

    logic             out_valid_reg;
    logic             out_valid_next;
    spt_pkg::result_t out_data_reg;
    spt_pkg::result_t out_data_next;
    logic             skid_valid_reg;
    logic             skid_valid_next;
    spt_pkg::result_t skid_data_reg;
    spt_pkg::result_t skid_data_next;
    logic             in_fire;

    assign in_ready = !skid_valid_reg;
    assign in_fire  = in_valid && in_ready;

    always_comb
    begin
        out_valid_next  = out_valid_reg;
        out_data_next   = out_data_reg;
        skid_valid_next = skid_valid_reg;
        skid_data_next  = skid_data_reg;
        if (!out_valid_reg || out_ready)
        begin
            if (skid_valid_reg)
            begin
                out_valid_next  = 1'b1;
                out_data_next   = skid_data_reg;
                skid_valid_next = 1'b0;
            end
            else
            begin
                out_valid_next = in_fire;
                out_data_next  = in_data;
            end
        end
        else if (in_fire)
        begin
            skid_valid_next = 1'b1;
            skid_data_next  = in_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg  <= out_valid_next;
            skid_valid_reg <= skid_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_data_reg  <= out_data_next;
        skid_data_reg <= skid_data_next;
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

`ifndef SYNTHESIS
    a_skid_behind_out: assert property (@(posedge clk) disable iff (!rst_n)
        skid_valid_reg |-> out_valid_reg)
        else $error("skid word without output word");
    a_skid_only_on_stall: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(skid_valid_reg) |-> $past(out_valid_reg && !out_ready && in_fire))
        else $error("skid filled without a stall");
    a_out_held_on_stall: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && !out_ready |=> out_valid_reg && $stable(out_data_reg))
        else $error("output word changed while stalled");
`endif

endmodule

`default_nettype wire

// ----- hdl/servo_pwm_timer_4ch.sv -----
// Four-channel servo PWM timer, top level. Depends on spt_pkg, spt_if,
// spt_core and spt_out_buf.
//
// item   : input words; cmd 0 advances the prescaler by one tick, cmd 1
//          preloads the compares from the clamped pulse values.
// result : one word per input word: channel levels, counter value and the
//          update flag.
// cfg    : register writes, index 0 period_reload, index 1 prescale_divide;
//          always ready, taken at once. Other indexes are ignored.
// Throughput: one word per cycle unless the result side stalls; the whole
// step is one pass of logic from the timer registers into the output register.
// Output: each result is registered in the output register, or the skid on a stall.
// Stall: a skid stage holds one more word, so item.ready drops only once a
// second result waits behind a stalled output.
// Reset: counters, compares and handshake state clear; period_reload comes
// out at all ones and prescale_divide at zero.
`default_nettype none

module servo_pwm_timer_4ch #(
    parameter int CHANNELS    = spt_pkg::CHANNELS_DEF,
    parameter int COUNT_WIDTH = spt_pkg::COUNT_WIDTH_DEF
) (
    input  wire logic     clk,
    input  wire logic     rst_n,
    spt_item_if.sink      item,
    spt_result_if.source  result,
    spt_cfg_if.sink       cfg
);

    logic                                   acc;
    logic                                   buf_ready;
    logic [spt_pkg::MAX_CHANNELS-1:0][15:0] pulse;
    spt_pkg::result_t                       core_res;
    spt_pkg::result_t                       out_res;

    assign item.ready = buf_ready;
    assign acc        = item.valid && buf_ready;
    assign cfg.ready  = 1'b1;

    assign pulse[0] = item.pulse_ch1;
    assign pulse[1] = item.pulse_ch2;
    assign pulse[2] = item.pulse_ch3;
    assign pulse[3] = item.pulse_ch4;

    spt_core #(
        .CHANNELS    (CHANNELS),
        .COUNT_WIDTH (COUNT_WIDTH)
    ) u_core (
        .clk       (clk),
        .rst_n     (rst_n),
        .acc       (acc),
        .cmd       (item.cmd),
        .pulse     (pulse),
        .cfg_we    (cfg.valid),
        .cfg_index (cfg.index),
        .cfg_data  (cfg.data),
        .res       (core_res)
    );

    spt_out_buf u_out_buf (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (item.valid),
        .in_ready  (buf_ready),
        .in_data   (core_res),
        .out_valid (result.valid),
        .out_ready (result.ready),
        .out_data  (out_res)
    );

    assign result.level_ch1    = out_res.level[0];
    assign result.level_ch2    = out_res.level[1];
    assign result.level_ch3    = out_res.level[2];
    assign result.level_ch4    = out_res.level[3];
    assign result.count_value  = out_res.count;
    assign result.update_event = out_res.update;

endmodule

`default_nettype wire

// ----- tb/tb_top.sv -----
`timescale 1ns / 1ps
// Self-checking bench for servo_pwm_timer_4ch: a scoreboard class tracks
// prescaler, counter and compares. Depends on spt_pkg, spt_if and the RTL.

module tb_top;

    localparam int unsigned CYCLE_LIMIT = 100_000;
    localparam logic [spt_pkg::CFG_INDEX_W-1:0] REG_SPARE_A = 2'd2;
    localparam logic [spt_pkg::CFG_INDEX_W-1:0] REG_SPARE_B = 2'd3;

    class timer_scoreboard;
        logic [15:0]      period_reload;
        logic [15:0]      prescale_divide;
        logic [15:0]      prescale_cnt;
        logic [15:0]      main_cnt;
        logic [15:0]      active_cmp [spt_pkg::MAX_CHANNELS];
        logic [15:0]      preload_cmp [spt_pkg::MAX_CHANNELS];
        spt_pkg::result_t levels_due [$];
        int unsigned      error_count;
        int unsigned      results_seen;

        function new();
            period_reload   = spt_pkg::PERIOD_RST[15:0];
            prescale_divide = '0;
            prescale_cnt    = '0;
            main_cnt        = '0;
            for (int ch = 0; ch < spt_pkg::MAX_CHANNELS; ch++)
            begin
                active_cmp[ch]  = '0;
                preload_cmp[ch] = '0;
            end
            error_count  = 0;
            results_seen = 0;
        endfunction

        function int pending();
            return levels_due.size();
        endfunction

        function void set_register(logic [spt_pkg::CFG_INDEX_W-1:0] idx,
                                   logic [15:0] value);
            if (idx == spt_pkg::REG_PERIOD_RELOAD)
                period_reload = value;
            else if (idx == spt_pkg::REG_PRESCALE_DIVIDE)
                prescale_divide = value;
        endfunction

        // advance the timer by one accepted word and queue the levels it gives
        function void note_word(logic cmd, logic [3:0][15:0] pulse);
            spt_pkg::result_t want;
            logic [15:0]      clamped;
            want = '0;
            if (cmd == spt_pkg::CMD_LOAD)
            begin
                for (int ch = 0; ch < spt_pkg::MAX_CHANNELS; ch++)
                begin
                    clamped = (pulse[ch] > spt_pkg::PULSE_LIMIT) ? spt_pkg::PULSE_LIMIT
                                                                 : pulse[ch];
                    preload_cmp[ch] = spt_pkg::COMPARE_BASE - clamped;
                end
            end
            else if (prescale_cnt >= prescale_divide)
            begin
                prescale_cnt = '0;
                if (main_cnt >= period_reload)
                begin
                    main_cnt    = '0;
                    want.update = 1'b1;
                    for (int ch = 0; ch < spt_pkg::MAX_CHANNELS; ch++)
                        active_cmp[ch] = preload_cmp[ch];
                end
                else
                    main_cnt = main_cnt + 16'd1;
            end
            else
                prescale_cnt = prescale_cnt + 16'd1;
            for (int ch = 0; ch < spt_pkg::MAX_CHANNELS; ch++)
                want.level[ch] = (main_cnt >= active_cmp[ch]);
            want.count = main_cnt;
            levels_due.push_back(want);
        endfunction

        task report(string msg);
            $display("[%0t] mismatch on result %0d: %s", $time, results_seen, msg);
            error_count++;
        endtask

        task check_result(spt_pkg::result_t got);
            spt_pkg::result_t want;
            results_seen++;
            if (levels_due.size() == 0)
            begin
                report($sformatf("unexpected word, count %0d", got.count));
                return;
            end
            want = levels_due.pop_front();
            for (int ch = 0; ch < spt_pkg::MAX_CHANNELS; ch++)
                if (got.level[ch] !== want.level[ch])
                    report($sformatf("level_ch%0d got %b want %b", ch + 1,
                                     got.level[ch], want.level[ch]));
            if (got.count !== want.count)
                report($sformatf("count_value got %0d want %0d", got.count, want.count));
            if (got.update !== want.update)
                report($sformatf("update_event got %b want %b", got.update, want.update));
        endtask
    endclass

    logic clk = 1'b0;
    logic rst_n;
    bit   gaps_enabled = 1'b1;
    int unsigned cycle_count = 0;
    timer_scoreboard sb = new();

    spt_item_if   item_bus ();
    spt_result_if result_bus ();
    spt_cfg_if    cfg_bus ();

    servo_pwm_timer_4ch u_dut (
        .clk    (clk),
        .rst_n  (rst_n),
        .item   (item_bus),
        .result (result_bus),
        .cfg    (cfg_bus)
    );

    always #5 clk = ~clk;

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("** servo_pwm_timer_4ch: FAILED **");
            $finish;
        end
    end

    always @(posedge clk)
    begin
        spt_pkg::result_t got;
        if (rst_n === 1'b1 && result_bus.valid && result_bus.ready)
        begin
            got.level  = {result_bus.level_ch4, result_bus.level_ch3,
                          result_bus.level_ch2, result_bus.level_ch1};
            got.count  = result_bus.count_value;
            got.update = result_bus.update_event;
            sb.check_result(got);
        end
    end

    // result side: random stall before each word
    initial
    begin
        int stall;
        result_bus.ready <= 1'b0;
        forever
        begin
            stall = gaps_enabled ? $urandom_range(0, 6) : 0;
            @(negedge clk);
            if (stall > 0)
            begin
                result_bus.ready <= 1'b0;
                repeat (stall) @(negedge clk);
            end
            result_bus.ready <= 1'b1;
            @(posedge clk);
            while (!(result_bus.valid === 1'b1 && rst_n === 1'b1))
                @(posedge clk);
        end
    end

    task automatic send_word(logic cmd, logic [3:0][15:0] pulse);
        int gap;
        gap = gaps_enabled ? $urandom_range(0, 6) : 0;
        @(negedge clk);
        if (gap > 0)
        begin
            item_bus.valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        item_bus.valid     <= 1'b1;
        item_bus.cmd       <= cmd;
        item_bus.pulse_ch1 <= pulse[0];
        item_bus.pulse_ch2 <= pulse[1];
        item_bus.pulse_ch3 <= pulse[2];
        item_bus.pulse_ch4 <= pulse[3];
        @(posedge clk);
        while (item_bus.ready !== 1'b1)
            @(posedge clk);
        sb.note_word(cmd, pulse);
    endtask

    task automatic drain_results();
        @(negedge clk);
        item_bus.valid <= 1'b0;
        while (sb.pending() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    task automatic write_reg(logic [spt_pkg::CFG_INDEX_W-1:0] idx, logic [15:0] value);
        @(negedge clk);
        cfg_bus.valid <= 1'b1;
        cfg_bus.index <= idx;
        cfg_bus.data  <= value;
        @(posedge clk);
        while (cfg_bus.ready !== 1'b1)
            @(posedge clk);
        sb.set_register(idx, value);
        @(negedge clk);
        cfg_bus.valid <= 1'b0;
    endtask

    function automatic logic [15:0] pick_pulse();
        case ($urandom_range(0, 5))
            0:       return 16'd0;
            1:       return spt_pkg::PULSE_LIMIT;
            2:       return 16'($urandom_range(990, 1010));
            3:       return 16'($urandom_range(0, 1000));
            default: return 16'($urandom);
        endcase
    endfunction

    task automatic send_random_word(int load_pct);
        logic [3:0][15:0] pulse;
        for (int ch = 0; ch < spt_pkg::MAX_CHANNELS; ch++)
            pulse[ch] = pick_pulse();
        send_word(($urandom_range(0, 99) < load_pct) ? spt_pkg::CMD_LOAD
                                                     : spt_pkg::CMD_TICK, pulse);
    endtask

    initial
    begin
        logic [15:0] period;
        logic [15:0] divide;
        int          words;

        rst_n              <= 1'b0;
        item_bus.valid     <= 1'b0;
        item_bus.cmd       <= spt_pkg::CMD_TICK;
        item_bus.pulse_ch1 <= '0;
        item_bus.pulse_ch2 <= '0;
        item_bus.pulse_ch3 <= '0;
        item_bus.pulse_ch4 <= '0;
        cfg_bus.valid      <= 1'b0;
        cfg_bus.index      <= spt_pkg::REG_PERIOD_RELOAD;
        cfg_bus.data       <= '0;
        repeat (7) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // reset settings: compares zero, all levels high
        send_word(spt_pkg::CMD_TICK, '0);
        send_word(spt_pkg::CMD_TICK, {16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF});
        send_word(spt_pkg::CMD_LOAD, {16'd65535, 16'd1001, 16'd1000, 16'd0});
        send_word(spt_pkg::CMD_TICK, '0);
        send_word(spt_pkg::CMD_LOAD, {16'h8000, 16'd32768, 16'd999, 16'd1});
        drain_results();

        // period below the counter: next advance wraps
        write_reg(spt_pkg::REG_PERIOD_RELOAD, 16'd1);
        send_word(spt_pkg::CMD_TICK, '0);
        send_word(spt_pkg::CMD_TICK, '0);
        send_word(spt_pkg::CMD_TICK, '0);
        send_word(spt_pkg::CMD_LOAD, {16'd1000, 16'd1000, 16'd1000, 16'd1000});
        send_word(spt_pkg::CMD_TICK, '0);
        send_word(spt_pkg::CMD_TICK, '0);
        drain_results();

        // slowest prescaler, then lowered under its count
        write_reg(spt_pkg::REG_PRESCALE_DIVIDE, 16'hFFFF);
        write_reg(spt_pkg::REG_PERIOD_RELOAD, 16'd0);
        repeat (4) send_word(spt_pkg::CMD_TICK, '0);
        drain_results();
        write_reg(spt_pkg::REG_PRESCALE_DIVIDE, 16'd2);
        repeat (5) send_word(spt_pkg::CMD_TICK, '0);
        drain_results();

        for (int phase = 0; phase < 8; phase++)
        begin
            case (phase)
                0:       begin period = 16'd0;     divide = 16'd0;     words = 130; end
                1:       begin period = 16'd1;     divide = 16'd1;     words = 130; end
                2:       begin period = 16'd5;     divide = 16'd0;     words = 140; end
                3:       begin period = 16'd12;    divide = 16'd3;     words = 140; end
                4:       begin period = 16'hFFFF;  divide = 16'd0;     words = 100; end
                5:       begin period = 16'd2;     divide = 16'hFFFF;  words = 40;  end
                6:       begin period = 16'd30;    divide = 16'd2;     words = 140; end
                default:
                begin
                    period = 16'($urandom_range(0, 40));
                    divide = 16'($urandom_range(0, 3));
                    words  = 150;
                end
            endcase
            if (phase == 4)
            begin
                write_reg(REG_SPARE_A, 16'($urandom));
                write_reg(REG_SPARE_B, 16'($urandom));
            end
            write_reg(spt_pkg::REG_PERIOD_RELOAD, period);
            write_reg(spt_pkg::REG_PRESCALE_DIVIDE, divide);
            for (int k = 0; k < words; k++)
            begin
                if (k % 50 == 0)
                    gaps_enabled = ($urandom_range(0, 3) != 0);
                if ($urandom_range(0, 199) == 0)
                    drain_results();
                send_random_word(15);
            end
            drain_results();
        end

        repeat (10) @(posedge clk);

        if (sb.error_count == 0)
            $display("** servo_pwm_timer_4ch: PASSED **");
        else
            $display("** servo_pwm_timer_4ch: FAILED **");
        $finish;
    end

endmodule
